[design/deque_with_delete_by_value_macros.svh]
// Assertion macros shared by the deque block.
`ifndef DEQUE_WITH_DELETE_BY_VALUE_MACROS_SVH
`define DEQUE_WITH_DELETE_BY_VALUE_MACROS_SVH

// Check a condition on every clock edge outside reset.
`define DWD_CHECK(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Check that a consequence holds in the same cycle as its cause.
`define DWD_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

[design/dwd_pkg.sv]
// Package with command codes, status codes and sequencer states of the deque.
package dwd_pkg;

  localparam int CMD_W    = 3;
  localparam int STATUS_W = 2;
  localparam int WORD_W   = 32;

  localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DELETE     = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOMATCH = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_POP_DATA,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_DONE
  } state_t;

endpackage

[design/deque_with_delete_by_value.sv]
// Bounded double-ended queue with delete-by-value, run by a small sequencer.
//
//   channel   handshake              payload
//   request   in_valid / in_ready    cmd, value
//   result    out_valid / out_ready  popped, count, status
//
// A push passes the EXEC and DONE states from accept to result; a pop from a non-empty
// queue also passes POP_DATA (one memory read). A delete reads and compares the entries
// in turn until the first match, then moves each later entry one place forward.
// The entry memory has one write port and one registered read port.
// Reset (synchronous) empties the queue; the memory itself is not cleared.
// A finished result waits in the output register while the next request is taken.
`include "deque_with_delete_by_value_macros.svh"

module deque_with_delete_by_value #(
  parameter int DEPTH = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [dwd_pkg::CMD_W-1:0]           cmd,
  input  logic signed [dwd_pkg::WORD_W-1:0]   value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [dwd_pkg::WORD_W-1:0]   popped,
  output logic [$clog2(DEPTH+1)-1:0]          count,
  output logic [dwd_pkg::STATUS_W-1:0]        status
);
  import dwd_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [AW-1:0] LAST_A  = AW'(DEPTH - 1);

  // Physical slot of an offset from the front, wrapped once around the store.
  function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
                                            input logic [CW-1:0] off);
    logic [SW-1:0] sum;
    sum = SW'(base) + SW'(off);
    if (sum >= SW'(DEPTH)) sum = sum - SW'(DEPTH);
    return sum[AW-1:0];
  endfunction

  state_t state, state_next;

  logic [AW-1:0]        front, front_next;
  logic [CW-1:0]        entry_count, entry_count_next;
  logic [CW-1:0]        idx, idx_next;
  logic [CMD_W-1:0]     cmd_q, cmd_q_next;
  logic [WORD_W-1:0]    val_q, val_q_next;
  logic [WORD_W-1:0]    res_popped, res_popped_next;
  logic [STATUS_W-1:0]  res_status, res_status_next;

  logic [WORD_W-1:0]    mem [DEPTH];
  logic [WORD_W-1:0]    rd_data;
  logic [AW-1:0]        raddr;
  logic [AW-1:0]        waddr;
  logic [WORD_W-1:0]    wdata;
  logic                 mem_we;

  logic                 is_full, is_empty, idx_last, out_load;

  assign is_full  = (entry_count == DEPTH_C);
  assign is_empty = (entry_count == '0);
  assign idx_last = ((idx + CW'(1)) == entry_count);
  assign out_load = (state == S_DONE) && (!out_valid || out_ready);
  assign in_ready = (state == S_IDLE);

  // Entry store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) mem[waddr] <= wdata;
    rd_data <= mem[raddr];
  end

  // Next state of the sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        unique case (cmd_q)
          CMD_POP_BACK, CMD_POP_FRONT: begin
            state_next = is_empty ? S_DONE : S_POP_DATA;
          end
          CMD_DELETE: begin
            state_next = is_empty ? S_DONE : S_SCAN_RD;
          end
          default: state_next = S_DONE;
        endcase
      end
      S_POP_DATA: state_next = S_DONE;
      S_SCAN_RD:  state_next = S_SCAN_CMP;
      S_SCAN_CMP: begin
        priority if (rd_data == val_q) state_next = S_SHIFT_RD;
        else if (idx_last)             state_next = S_DONE;
        else                           state_next = S_SCAN_RD;
      end
      S_SHIFT_RD: state_next = idx_last ? S_DONE : S_SHIFT_WR;
      S_SHIFT_WR: state_next = S_SHIFT_RD;
      S_DONE: begin
        if (out_load) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Datapath controls and register updates per state
  always_comb begin
    front_next       = front;
    entry_count_next = entry_count;
    idx_next         = idx;
    cmd_q_next       = cmd_q;
    val_q_next       = val_q;
    res_popped_next  = res_popped;
    res_status_next  = res_status;
    raddr            = front;
    waddr            = front;
    wdata            = val_q;
    mem_we           = 1'b0;
    unique case (state)
      S_IDLE: begin
        // latch the request
        if (in_valid) begin
          cmd_q_next      = cmd;
          val_q_next      = value;
          res_popped_next = '0;
          res_status_next = ST_OK;
        end
      end
      S_EXEC: begin
        unique case (cmd_q)
          CMD_PUSH_BACK: begin
            if (is_full) begin
              res_status_next = ST_FULL;
            end else begin
              waddr            = slot_of(front, entry_count);
              mem_we           = 1'b1;
              entry_count_next = entry_count + CW'(1);
            end
          end
          CMD_POP_BACK: begin
            if (is_empty) begin
              res_status_next = ST_EMPTY;
            end else begin
              raddr            = slot_of(front, entry_count - CW'(1));
              entry_count_next = entry_count - CW'(1);
            end
          end
          CMD_PUSH_FRONT: begin
            if (is_full) begin
              res_status_next = ST_FULL;
            end else begin
              front_next       = (front == '0) ? LAST_A : front - AW'(1);
              waddr            = front_next;
              mem_we           = 1'b1;
              entry_count_next = entry_count + CW'(1);
            end
          end
          CMD_POP_FRONT: begin
            if (is_empty) begin
              res_status_next = ST_EMPTY;
            end else begin
              raddr            = front;
              front_next       = (front == LAST_A) ? '0 : front + AW'(1);
              entry_count_next = entry_count - CW'(1);
            end
          end
          CMD_DELETE: begin
            res_status_next = ST_NOMATCH;
            idx_next        = '0;
          end
          default: ;
        endcase
      end
      S_POP_DATA: res_popped_next = rd_data;
      S_SCAN_RD:  raddr = slot_of(front, idx);
      S_SCAN_CMP: begin
        // stop on the first match, else advance
        if (rd_data == val_q) res_status_next = ST_OK;
        else if (!idx_last)   idx_next = idx + CW'(1);
      end
      S_SHIFT_RD: begin
        if (idx_last) entry_count_next = entry_count - CW'(1);
        else          raddr = slot_of(front, idx + CW'(1));
      end
      S_SHIFT_WR: begin
        // move the later entry one place toward the front
        waddr    = slot_of(front, idx);
        wdata    = rd_data;
        mem_we   = 1'b1;
        idx_next = idx + CW'(1);
      end
      S_DONE: ;
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      front       <= '0;
      entry_count <= '0;
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      front       <= front_next;
      entry_count <= entry_count_next;
      if (out_load)       out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    idx        <= idx_next;
    cmd_q      <= cmd_q_next;
    val_q      <= val_q_next;
    res_popped <= res_popped_next;
    res_status <= res_status_next;
    if (out_load) begin
      popped <= res_popped;
      count  <= entry_count;
      status <= res_status;
    end
  end

  `DWD_CHECK(a_count_bound, entry_count <= DEPTH_C, "entry count beyond depth")
  `DWD_IMPLY(a_full_count, out_valid && status == ST_FULL, count == DEPTH_C, "full, room left")
  `DWD_IMPLY(a_empty_pop, out_valid && status == ST_EMPTY, popped == '0 && count == '0, "bad pop")

endmodule
